[design/rfbe_pkg.sv]
// ----------------------------------------------------------------------------
// rfbe_pkg
// Shared constants and codes for the RNS fast base extension block.
// ----------------------------------------------------------------------------
package rfbe_pkg;

   localparam int MAX_Q_LIMBS = 16;
   localparam int MAX_P_LIMBS = 16;
   localparam int WORD_BITS   = 60;

   localparam int Q_IDX_BITS  = 4;
   localparam int P_IDX_BITS  = 4;
   localparam int KIND_BITS   = 2;
   localparam int COUNT_BITS  = 5;
   localparam int LIMB_CNT_BITS = $clog2(MAX_P_LIMBS + 1);
   localparam int BIT_CNT_BITS  = $clog2(WORD_BITS);
   localparam int QHP_ADDR_BITS = Q_IDX_BITS + P_IDX_BITS;
   localparam int QHP_DEPTH     = MAX_Q_LIMBS * MAX_P_LIMBS;
   localparam int CSR_IDX_BITS  = 1;

   // operation codes
   localparam logic OP_TABLE   = 1'b0;
   localparam logic OP_RESIDUE = 1'b1;

   // table kinds
   localparam logic [KIND_BITS-1:0] KIND_Q_MOD    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_QHAT_INV = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_P_MOD    = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_QHAT_P   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_Q_COUNT = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_P_COUNT = 1'd1;

   // sequencer states
   localparam int ST_BITS = 4;
   localparam logic [ST_BITS-1:0] ST_IDLE    = 4'd0;
   localparam logic [ST_BITS-1:0] ST_ECHO    = 4'd1;
   localparam logic [ST_BITS-1:0] ST_MULV    = 4'd2;
   localparam logic [ST_BITS-1:0] ST_RDJ     = 4'd3;
   localparam logic [ST_BITS-1:0] ST_MULT_GO = 4'd4;
   localparam logic [ST_BITS-1:0] ST_MULT    = 4'd5;
   localparam logic [ST_BITS-1:0] ST_ACCR    = 4'd6;
   localparam logic [ST_BITS-1:0] ST_SKIP    = 4'd7;
   localparam logic [ST_BITS-1:0] ST_EMIT    = 4'd8;

   typedef logic [WORD_BITS-1:0] word_type;

   // clamp a raw count register value into 1..max
   function automatic logic [COUNT_BITS-1:0] clamp_count(
      input logic [COUNT_BITS-1:0] raw,
      input logic [COUNT_BITS-1:0] max_val);
      logic [COUNT_BITS-1:0] res;
      if (raw == '0) begin
         res = COUNT_BITS'(1);
      end else if (raw > max_val) begin
         res = max_val;
      end else begin
         res = raw;
      end
      return res;
   endfunction

endpackage

[design/rfbe_if.sv]
// ----------------------------------------------------------------------------
// rfbe_req_if / rfbe_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface rfbe_req_if;
   logic                              valid;
   logic                              ready;
   logic                              operation;
   logic [rfbe_pkg::KIND_BITS-1:0]    table_kind;
   logic [rfbe_pkg::Q_IDX_BITS-1:0]   q_index;
   logic [rfbe_pkg::P_IDX_BITS-1:0]   p_index;
   logic [rfbe_pkg::WORD_BITS-1:0]    word_value;

   modport source (output valid, operation, table_kind, q_index, p_index, word_value,
                   input ready);
   modport sink   (input valid, operation, table_kind, q_index, p_index, word_value,
                   output ready);
endinterface

interface rfbe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rfbe_pkg::WORD_BITS-1:0]    result_value;
   logic                              is_p_limb;
   logic [rfbe_pkg::P_IDX_BITS-1:0]   limb_number;
   logic                              column_done;

   modport source (output valid, result_value, is_p_limb, limb_number, column_done,
                   input ready);
   modport sink   (input valid, result_value, is_p_limb, limb_number, column_done,
                   output ready);
endinterface

[design/rns_fast_base_extension.sv]
// ----------------------------------------------------------------------------
// rns_fast_base_extension
// Extends one coefficient column from base Q to base Q plus P.
// ----------------------------------------------------------------------------
// Table write or ignored residue: accepted while idle, next item the cycle after.
// Residue: one multiplier pass for the Q-side product, then two passes of the
//   bit-serial multiplier (W = 60) per P limb, plus one shift per unused ring cell;
//   the last limb of a column adds a shift-out of all 16 ring cells, which waits while results stall.
// One item in flight; rate is set by the single shared modular multiplier.
// Synchronous active-high reset clears control, counts (to 1) and accumulators.
module rns_fast_base_extension (
   input  logic                                    clock,
   input  logic                                    reset,
   rfbe_req_if.sink                                req_chan,
   rfbe_rsp_if.source                              rsp_chan,
   input  logic                                    csr_we,
   input  logic [rfbe_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [rfbe_pkg::COUNT_BITS-1:0]         csr_wdata
);

   localparam int NP = rfbe_pkg::MAX_P_LIMBS;
   localparam int W  = rfbe_pkg::WORD_BITS;

   logic [rfbe_pkg::ST_BITS-1:0]        state_ff, state_in;
   logic [rfbe_pkg::COUNT_BITS-1:0]     nq_ff, nq_in, np_ff, np_in;
   logic [rfbe_pkg::LIMB_CNT_BITS-1:0]  j_ff, j_in;
   logic [rfbe_pkg::Q_IDX_BITS-1:0]     qi_ff, qi_in;
   rfbe_pkg::word_type                  x_ff, x_in, v_ff, v_in, t_ff, t_in;

   rfbe_pkg::word_type q_mod_tab  [rfbe_pkg::MAX_Q_LIMBS];
   rfbe_pkg::word_type q_inv_tab  [rfbe_pkg::MAX_Q_LIMBS];
   rfbe_pkg::word_type p_mod_tab  [rfbe_pkg::MAX_P_LIMBS];
   rfbe_pkg::word_type qhp_mem    [rfbe_pkg::QHP_DEPTH];
   rfbe_pkg::word_type qhp_rd_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   rfbe_pkg::word_type                  rsp_val_ff, rsp_val_in;
   logic                                rsp_isp_ff, rsp_isp_in;
   logic [rfbe_pkg::P_IDX_BITS-1:0]     rsp_limb_ff, rsp_limb_in;
   logic                                rsp_done_ff, rsp_done_in;

   logic                                out_free, accept, load_rsp;
   logic                                mul_start, mul_busy, mul_done;
   rfbe_pkg::word_type                  mul_a, mul_b, mul_m, mul_res;
   logic                                ring_shift;
   rfbe_pkg::word_type                  ring_tail;
   rfbe_pkg::word_type                  ring [NP];
   logic [rfbe_pkg::P_IDX_BITS-1:0]     j_idx;
   logic [W:0]                          acc_sum, acc_red;
   logic [rfbe_pkg::QHP_ADDR_BITS-1:0]  qhp_waddr, qhp_raddr;
   rfbe_pkg::word_type                  p_cur;
   logic                                last_rot;

   assign j_idx     = j_ff[rfbe_pkg::P_IDX_BITS-1:0];
   assign p_cur     = p_mod_tab[j_idx];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == rfbe_pkg::ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign qhp_waddr = {req_chan.q_index, req_chan.p_index};
   assign qhp_raddr = {qi_ff, j_idx};
   assign last_rot  = (j_ff == rfbe_pkg::LIMB_CNT_BITS'(NP - 1));

   // accumulator ring, cell 0 is the head under work
   genvar k;
   generate
      for (k = 0; k < NP; k++) begin : g_ring
         rfbe_pkg::word_type cell_d;
         if (k == NP - 1) begin : g_tail
            assign cell_d = ring_tail;
         end else begin : g_mid
            assign cell_d = ring[k+1];
         end
         rfbe_acc_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring_shift),
            .d_in  (cell_d),
            .q_out (ring[k])
         );
      end
   endgenerate

   rfbe_modmul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a_val  (mul_a),
      .b_val  (mul_b),
      .m_val  (mul_m),
      .busy   (mul_busy),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      acc_sum = {1'b0, mul_res} + {1'b0, t_ff};
      acc_red = (acc_sum >= {1'b0, p_cur}) ? acc_sum - {1'b0, p_cur} : acc_sum;

      state_in   = state_ff;
      j_in       = j_ff;
      qi_in      = qi_ff;
      x_in       = x_ff;
      v_in       = v_ff;
      t_in       = t_ff;
      mul_start  = 1'b0;
      mul_a      = v_ff;
      mul_b      = qhp_rd_ff;
      mul_m      = p_cur;
      ring_shift = 1'b0;
      ring_tail  = ring[0];
      load_rsp   = 1'b0;
      rsp_val_in  = rsp_val_ff;
      rsp_isp_in  = rsp_isp_ff;
      rsp_limb_in = rsp_limb_ff;
      rsp_done_in = rsp_done_ff;

      case (state_ff)
         rfbe_pkg::ST_IDLE: begin
            if (accept && req_chan.operation == rfbe_pkg::OP_RESIDUE &&
                {1'b0, req_chan.q_index} < nq_ff) begin
               qi_in    = req_chan.q_index;
               x_in     = req_chan.word_value;
               state_in = rfbe_pkg::ST_ECHO;
            end
         end
         rfbe_pkg::ST_ECHO: begin
            mul_a = x_ff;
            mul_b = q_inv_tab[qi_ff];
            mul_m = q_mod_tab[qi_ff];
            if (out_free) begin
               load_rsp    = 1'b1;
               rsp_val_in  = x_ff;
               rsp_isp_in  = 1'b0;
               rsp_limb_in = qi_ff;
               rsp_done_in = 1'b0;
               mul_start   = 1'b1;
               state_in    = rfbe_pkg::ST_MULV;
            end
         end
         rfbe_pkg::ST_MULV: begin
            if (mul_done) begin
               v_in     = mul_res;
               j_in     = '0;
               state_in = rfbe_pkg::ST_RDJ;
            end
         end
         rfbe_pkg::ST_RDJ: begin
            state_in = rfbe_pkg::ST_MULT_GO;
         end
         rfbe_pkg::ST_MULT_GO: begin
            mul_start = 1'b1;
            state_in  = rfbe_pkg::ST_MULT;
         end
         rfbe_pkg::ST_MULT: begin
            // reduce the head accumulator: acc * 1 mod p
            mul_a = ring[0];
            mul_b = W'(1);
            if (mul_done) begin
               t_in      = mul_res;
               mul_start = 1'b1;
               state_in  = rfbe_pkg::ST_ACCR;
            end
         end
         rfbe_pkg::ST_ACCR: begin
            if (mul_done) begin
               ring_shift = 1'b1;
               ring_tail  = acc_red[W-1:0];
               j_in       = j_ff + 1'b1;
               if (last_rot) begin
                  j_in     = '0;
                  state_in = (qi_ff == rfbe_pkg::Q_IDX_BITS'(nq_ff - 1'b1)) ?
                             rfbe_pkg::ST_EMIT : rfbe_pkg::ST_IDLE;
               end else if (j_in == rfbe_pkg::LIMB_CNT_BITS'(np_ff)) begin
                  state_in = rfbe_pkg::ST_SKIP;
               end else begin
                  state_in = rfbe_pkg::ST_RDJ;
               end
            end
         end
         rfbe_pkg::ST_SKIP: begin
            ring_shift = 1'b1;
            j_in       = j_ff + 1'b1;
            if (last_rot) begin
               j_in     = '0;
               state_in = (qi_ff == rfbe_pkg::Q_IDX_BITS'(nq_ff - 1'b1)) ?
                          rfbe_pkg::ST_EMIT : rfbe_pkg::ST_IDLE;
            end
         end
         rfbe_pkg::ST_EMIT: begin
            // shift out and clear; results only for the first np limbs
            ring_tail = '0;
            if (j_ff < rfbe_pkg::LIMB_CNT_BITS'(np_ff)) begin
               if (out_free) begin
                  load_rsp    = 1'b1;
                  rsp_val_in  = ring[0];
                  rsp_isp_in  = 1'b1;
                  rsp_limb_in = j_idx;
                  rsp_done_in = (j_ff == rfbe_pkg::LIMB_CNT_BITS'(np_ff - 1'b1));
                  ring_shift  = 1'b1;
               end
            end else begin
               ring_shift = 1'b1;
            end
            if (ring_shift) begin
               j_in = j_ff + 1'b1;
               if (last_rot) begin
                  j_in     = '0;
                  state_in = rfbe_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rfbe_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end

      nq_in = nq_ff;
      np_in = np_ff;
      if (csr_we) begin
         case (csr_index)
            rfbe_pkg::CSR_Q_COUNT: begin
               nq_in = rfbe_pkg::clamp_count(csr_wdata,
                                             rfbe_pkg::COUNT_BITS'(rfbe_pkg::MAX_Q_LIMBS));
            end
            rfbe_pkg::CSR_P_COUNT: begin
               np_in = rfbe_pkg::clamp_count(csr_wdata,
                                             rfbe_pkg::COUNT_BITS'(rfbe_pkg::MAX_P_LIMBS));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfbe_pkg::ST_IDLE;
         j_ff         <= '0;
         nq_ff        <= rfbe_pkg::COUNT_BITS'(1);
         np_ff        <= rfbe_pkg::COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         nq_ff        <= nq_in;
         np_ff        <= np_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qi_ff       <= qi_in;
      x_ff        <= x_in;
      v_ff        <= v_in;
      t_ff        <= t_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_isp_ff  <= rsp_isp_in;
      rsp_limb_ff <= rsp_limb_in;
      rsp_done_ff <= rsp_done_in;
   end

   // table storage
   always_ff @(posedge clock) begin
      if (accept && req_chan.operation == rfbe_pkg::OP_TABLE) begin
         case (req_chan.table_kind)
            rfbe_pkg::KIND_Q_MOD:    q_mod_tab[req_chan.q_index] <= req_chan.word_value;
            rfbe_pkg::KIND_QHAT_INV: q_inv_tab[req_chan.q_index] <= req_chan.word_value;
            rfbe_pkg::KIND_P_MOD:    p_mod_tab[req_chan.p_index] <= req_chan.word_value;
            rfbe_pkg::KIND_QHAT_P:   qhp_mem[qhp_waddr]          <= req_chan.word_value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      qhp_rd_ff <= qhp_mem[qhp_raddr];
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_val_ff;
   assign rsp_chan.is_p_limb    = rsp_isp_ff;
   assign rsp_chan.limb_number  = rsp_limb_ff;
   assign rsp_chan.column_done  = rsp_done_ff;

   // multiplier is only started while idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   // a loaded result never overwrites one that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result overwritten");

   // column end is marked only on the last P limb
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |->
         (rsp_isp_ff && {1'b0, rsp_limb_ff} == np_ff - 1'b1))
      else $error("column_done on wrong limb");

   // multiplier results only arrive in states that wait for them
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == rfbe_pkg::ST_MULV || state_ff == rfbe_pkg::ST_MULT ||
                    state_ff == rfbe_pkg::ST_ACCR))
      else $error("unexpected multiplier result");

endmodule

[design/rfbe_modmul.sv]
// ----------------------------------------------------------------------------
// rfbe_modmul
// Bit-serial modular multiplier: reduces a mod m, then double-and-add over b.
// ----------------------------------------------------------------------------
module rfbe_modmul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rfbe_pkg::word_type   a_val,
   input  rfbe_pkg::word_type   b_val,
   input  rfbe_pkg::word_type   m_val,
   output logic                 busy,
   output logic                 done,
   output rfbe_pkg::word_type   result
);

   localparam int W = rfbe_pkg::WORD_BITS;

   logic                               busy_ff, busy_in;
   logic                               phase_ff, phase_in;
   logic                               done_ff, done_in;
   logic [rfbe_pkg::BIT_CNT_BITS-1:0]  cnt_ff, cnt_in;
   rfbe_pkg::word_type                 a_ff, a_in;
   rfbe_pkg::word_type                 b_ff, b_in;
   rfbe_pkg::word_type                 m_ff, m_in;
   rfbe_pkg::word_type                 r_ff, r_in;
   rfbe_pkg::word_type                 ared_ff, ared_in;
   rfbe_pkg::word_type                 res_ff, res_in;

   logic [W:0] red_sum, red_val;
   logic [W:0] dbl, dbl_red, add_sum, add_red;

   always_comb begin
      // reduction step: shift in the next bit of a
      red_sum = {r_ff, a_ff[cnt_ff]};
      red_val = (red_sum >= {1'b0, m_ff}) ? red_sum - {1'b0, m_ff} : red_sum;
      // multiply step: double, then add reduced a when the bit of b is set
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      add_sum = dbl_red + (b_ff[cnt_ff] ? {1'b0, ared_ff} : '0);
      add_red = (add_sum >= {1'b0, m_ff}) ? add_sum - {1'b0, m_ff} : add_sum;

      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      ared_in  = ared_ff;
      res_in   = res_ff;

      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = rfbe_pkg::BIT_CNT_BITS'(W - 1);
         a_in     = a_val;
         b_in     = b_val;
         m_in     = m_val;
         r_in     = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (!phase_ff) begin
            r_in = red_val[W-1:0];
            if (cnt_ff == '0) begin
               ared_in  = red_val[W-1:0];
               r_in     = '0;
               phase_in = 1'b1;
               cnt_in   = rfbe_pkg::BIT_CNT_BITS'(W - 1);
            end
         end else begin
            r_in = add_red[W-1:0];
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               // a zero modulus yields zero
               res_in  = (m_ff == '0) ? '0 : add_red[W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      m_ff     <= m_in;
      r_ff     <= r_in;
      ared_ff  <= ared_in;
      res_ff   <= res_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff;

endmodule

[design/rfbe_acc_cell.sv]
// ----------------------------------------------------------------------------
// rfbe_acc_cell
// One accumulator stage of the rotating P-limb ring.
// ----------------------------------------------------------------------------
module rfbe_acc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  rfbe_pkg::word_type   d_in,
   output rfbe_pkg::word_type   q_out
);

   rfbe_pkg::word_type acc_ff, acc_in;

   always_comb begin
      acc_in = shift ? d_in : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign q_out = acc_ff;

endmodule

[dv/tb_rns_fast_base_extension.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rns_fast_base_extension
// Loads the base tables, runs a directed table of items with zero, unit and
// all-ones moduli, then random columns over several Q/P limb counts. Every
// result is checked against a local base-extension predictor.
// ----------------------------------------------------------------------------
module tb_rns_fast_base_extension;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 5000;

   typedef struct {
      logic                           op;
      logic [rfbe_pkg::KIND_BITS-1:0] kind;
      logic [3:0]                     qi;
      logic [3:0]                     pj;
      rfbe_pkg::word_type             word;
      bit                             typed;
      rfbe_pkg::word_type             typed_p;
   } stim_type;

   typedef struct {
      rfbe_pkg::word_type value;
      logic               is_p;
      logic [3:0]         limb;
      logic               done;
   } limb_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [rfbe_pkg::CSR_IDX_BITS-1:0] csr_index = rfbe_pkg::CSR_Q_COUNT;
   logic [rfbe_pkg::COUNT_BITS-1:0]   csr_wdata = '0;

   rfbe_req_if req_if ();
   rfbe_rsp_if rsp_if ();

   rns_fast_base_extension DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   rfbe_pkg::word_type q_mod  [rfbe_pkg::MAX_Q_LIMBS];
   rfbe_pkg::word_type q_inv  [rfbe_pkg::MAX_Q_LIMBS];
   rfbe_pkg::word_type p_mod  [rfbe_pkg::MAX_P_LIMBS];
   rfbe_pkg::word_type qhat_p [rfbe_pkg::QHP_DEPTH];
   rfbe_pkg::word_type accum  [rfbe_pkg::MAX_P_LIMBS];
   logic [rfbe_pkg::COUNT_BITS-1:0] q_count_reg = 5'd1;
   logic [rfbe_pkg::COUNT_BITS-1:0] p_count_reg = 5'd1;

   limb_result_type expected_limbs [$];
   int  fails = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  req_typed = 1'b0;
   rfbe_pkg::word_type req_typed_p = '0;
   int  rsp_stall = 0;

   function automatic int eff_count(input logic [rfbe_pkg::COUNT_BITS-1:0] raw,
                                    input int max_val);
      if (raw == 0) return 1;
      return (raw > max_val) ? max_val : int'(raw);
   endfunction

   function automatic rfbe_pkg::word_type mod_mul(input rfbe_pkg::word_type a,
                                                  input rfbe_pkg::word_type b,
                                                  input rfbe_pkg::word_type m);
      logic [119:0] prod;
      if (m == 0) return '0;
      prod = {60'd0, a % m} * {60'd0, b % m};
      return rfbe_pkg::word_type'(prod % {60'd0, m});
   endfunction

   function automatic rfbe_pkg::word_type rand_word();
      return rfbe_pkg::word_type'({$urandom, $urandom});
   endfunction

   function automatic rfbe_pkg::word_type rand_big_modulus();
      return {1'b1, 59'(rand_word())};
   endfunction

   // base extension of one accepted item
   task automatic extend_item(input stim_type s);
      int nq, np;
      rfbe_pkg::word_type v, t, m;
      logic [60:0] sum;
      limb_result_type r;
      nq = eff_count(q_count_reg, rfbe_pkg::MAX_Q_LIMBS);
      np = eff_count(p_count_reg, rfbe_pkg::MAX_P_LIMBS);
      if (s.op == rfbe_pkg::OP_TABLE) begin
         case (s.kind)
            rfbe_pkg::KIND_Q_MOD:    q_mod[s.qi] = s.word;
            rfbe_pkg::KIND_QHAT_INV: q_inv[s.qi] = s.word;
            rfbe_pkg::KIND_P_MOD:    p_mod[s.pj] = s.word;
            default:                 qhat_p[{s.qi, s.pj}] = s.word;
         endcase
         return;
      end
      if (s.qi >= nq) return;
      r = '{s.word, 1'b0, s.qi, 1'b0};
      expected_limbs = {expected_limbs, r};
      v = mod_mul(s.word, q_inv[s.qi], q_mod[s.qi]);
      for (int j = 0; j < np; j++) begin
         m = p_mod[j];
         t = mod_mul(v, qhat_p[{s.qi, 4'(j)}], m);
         if (m == 0) begin
            accum[j] = '0;
         end else begin
            sum = {1'b0, accum[j] % m} + {1'b0, t};
            accum[j] = rfbe_pkg::word_type'(sum % {1'b0, m});
         end
      end
      if (s.qi == nq - 1) begin
         for (int j = 0; j < np; j++) begin
            r = '{s.typed ? s.typed_p : accum[j], 1'b1, 4'(j), j == np - 1};
            expected_limbs = {expected_limbs, r};
         end
         foreach (accum[j]) accum[j] = '0;
      end
   endtask

   // acceptance monitor, checker and watchdog
   always @(posedge clock) begin
      stim_type s;
      limb_result_type e;
      bit moved;
      moved = 1'b0;
      if (!reset && req_if.valid && req_if.ready) begin
         s = '{req_if.operation, req_if.table_kind, req_if.q_index, req_if.p_index,
               req_if.word_value, req_typed, req_typed_p};
         extend_item(s);
         moved = 1'b1;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         moved = 1'b1;
         if (expected_limbs.size() == 0) begin
            $error("unexpected result item value=%h", rsp_if.result_value);
            fails++;
         end else begin
            e = expected_limbs.pop_front();
            if (rsp_if.result_value !== e.value) begin
               $error("result_value exp=%h act=%h", e.value, rsp_if.result_value);
               fails++;
            end
            if (rsp_if.is_p_limb !== e.is_p) begin
               $error("is_p_limb exp=%0d act=%0d", e.is_p, rsp_if.is_p_limb);
               fails++;
            end
            if (rsp_if.limb_number !== e.limb) begin
               $error("limb_number exp=%0d act=%0d", e.limb, rsp_if.limb_number);
               fails++;
            end
            if (rsp_if.column_done !== e.done) begin
               $error("column_done exp=%0d act=%0d", e.done, rsp_if.column_done);
               fails++;
            end
         end
      end
      idle_cycles = (moved || reset) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result-side backpressure
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_if.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(0, 14);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_item(input stim_type s);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.operation  <= s.op;
      req_if.table_kind <= s.kind;
      req_if.q_index    <= s.qi;
      req_if.p_index    <= s.pj;
      req_if.word_value <= s.word;
      req_typed         <= s.typed;
      req_typed_p       <= s.typed_p;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_counts(input logic [rfbe_pkg::COUNT_BITS-1:0] qc,
                               input logic [rfbe_pkg::COUNT_BITS-1:0] pc);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_limbs.size() != 0) @(posedge clock);
      // compute may still be running after the last echo
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1; csr_index <= rfbe_pkg::CSR_Q_COUNT; csr_wdata <= qc;
      @(posedge clock);
      q_count_reg = qc;
      csr_index <= rfbe_pkg::CSR_P_COUNT; csr_wdata <= pc;
      @(posedge clock);
      p_count_reg = pc;
      csr_we <= 1'b0;
   endtask

   function automatic rfbe_pkg::word_type rand_modulus();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return rfbe_pkg::word_type'(1);
         2:       return '1;
         3:       return rfbe_pkg::word_type'($urandom_range(2, 1000));
         default: return rand_big_modulus();
      endcase
   endfunction

   // more than two P limbs only with a single Q limb, so every read entry is written
   task automatic run_phase(input logic [rfbe_pkg::COUNT_BITS-1:0] qc,
                            input logic [rfbe_pkg::COUNT_BITS-1:0] pc, input int n_items);
      int nq, sent;
      stim_type s;
      write_counts(qc, pc);
      nq = eff_count(qc, rfbe_pkg::MAX_Q_LIMBS);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            for (int i = 0; i < nq; i++) begin
               s = '{rfbe_pkg::OP_RESIDUE, 2'($urandom), 4'(i), 4'($urandom), rand_word(),
                     1'b0, '0};
               send_item(s);
            end
            sent += nq;
         end else if ($urandom_range(0, 1) == 0) begin
            s = '{rfbe_pkg::OP_TABLE, 2'($urandom), 4'($urandom), 4'($urandom), '0,
                  1'b0, '0};
            s.word = (s.kind inside {rfbe_pkg::KIND_Q_MOD, rfbe_pkg::KIND_P_MOD}) ?
                     rand_modulus() : rand_word();
            send_item(s);
            sent++;
         end else begin
            // stray or repeated limb
            s = '{rfbe_pkg::OP_RESIDUE, 2'($urandom), 4'($urandom), 4'($urandom),
                  rand_word(), 1'b0, '0};
            send_item(s);
            if (s.qi < nq) sent++;
         end
      end
   endtask

   stim_type dir_rows [20];

   initial begin
      foreach (accum[j]) accum[j] = '0;
      req_if.valid = 1'b0;
      req_if.operation = rfbe_pkg::OP_TABLE;
      req_if.table_kind = rfbe_pkg::KIND_Q_MOD;
      req_if.q_index = '0;
      req_if.p_index = '0;
      req_if.word_value = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every entry that the phases below can read
      for (int i = 0; i < rfbe_pkg::MAX_Q_LIMBS; i++) begin
         send_item(stim_type'{rfbe_pkg::OP_TABLE, rfbe_pkg::KIND_Q_MOD, 4'(i), 4'($urandom),
                              rand_big_modulus(), 1'b0, '0});
         send_item(stim_type'{rfbe_pkg::OP_TABLE, rfbe_pkg::KIND_QHAT_INV, 4'(i),
                              4'($urandom), rand_word(), 1'b0, '0});
         send_item(stim_type'{rfbe_pkg::OP_TABLE, rfbe_pkg::KIND_P_MOD, 4'($urandom), 4'(i),
                              rand_big_modulus(), 1'b0, '0});
         for (int j = 0; j < 2; j++)
            send_item(stim_type'{rfbe_pkg::OP_TABLE, rfbe_pkg::KIND_QHAT_P, 4'(i), 4'(j),
                                 rand_word(), 1'b0, '0});
      end
      for (int j = 2; j < rfbe_pkg::MAX_P_LIMBS; j++)
         send_item(stim_type'{rfbe_pkg::OP_TABLE, rfbe_pkg::KIND_QHAT_P, 4'd0, 4'(j),
                              rand_word(), 1'b0, '0});

      dir_rows = '{
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  60'd0,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_QHAT_P,   4'd0,  4'd15, '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  60'd0,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  60'h123456789abcdef,
           1'b1, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_P_MOD,    4'd0,  4'd0,  60'd0,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_P_MOD,    4'd0,  4'd0,  '1,
           1'b1, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_P_MOD,    4'd0,  4'd0,  '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_QHAT_INV, 4'd0,  4'd0,  '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_QHAT_P,   4'd0,  4'd0,  '1,
           1'b0, 60'd0},
         // all-ones residue reduces to zero mod all-ones modulus
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  '1,
           1'b1, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  '1 - 60'd1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_P_MOD,    4'd0,  4'd0,  60'd1,
           1'b1, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  60'hfedcba987654321,
           1'b1, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_P_MOD,    4'd0,  4'd0,  60'hffffffffffffc5,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_QHAT_INV, 4'd0,  4'd0,  60'd1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_TABLE,   rfbe_pkg::KIND_QHAT_P,   4'd15, 4'd15, '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd5,  4'd0,  60'd77,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd15, 4'd0,  '1,
           1'b0, 60'd0},
         '{rfbe_pkg::OP_RESIDUE, rfbe_pkg::KIND_Q_MOD,    4'd0,  4'd0,  60'h555555555555555,
           1'b0, 60'd0}
      };
      foreach (dir_rows[k]) send_item(dir_rows[k]);

      run_phase(5'd31, 5'd2,  32);
      run_phase(5'd1,  5'd31, 8);
      run_phase(5'd0,  5'd0,  12);
      run_phase(5'd3,  5'd2,  20);
      run_phase(5'd6,  5'd1,  12);
      quiet = 1'b1;
      run_phase(5'd4,  5'd2,  12);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_limbs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
design/rfbe_pkg.sv
design/rfbe_if.sv
design/rfbe_modmul.sv
design/rfbe_acc_cell.sv
design/rns_fast_base_extension.sv
dv/tb_rns_fast_base_extension.sv
